### rtl/rsbd_pkg.sv
package rsbd_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] RegLeftX   = 2'd0;
   localparam logic [1:0] RegBottomY = 2'd1;
   localparam logic [1:0] RegRightX  = 2'd2;
   localparam logic [1:0] RegTopY    = 2'd3;

   // region codes
   localparam logic [1:0] RegionOutside  = 2'd0;
   localparam logic [1:0] RegionBoundary = 2'd1;
   localparam logic [1:0] RegionInside   = 2'd2;

   // square root pipeline shape
   localparam int SqrtSteps     = 33;
   localparam int StepsPerStage = 3;
   localparam int SqrtStages    = SqrtSteps / StepsPerStage;

   // control that travels with each item
   typedef struct packed {
      logic       valid;
      logic [1:0] region;
   } tag_type;

   // state of the digit-by-digit square root
   typedef struct packed {
      logic [65:0] rad;
      logic [35:0] rem;
      logic [32:0] root;
   } sq_state_type;

   // magnitude of the difference of two signed words
   function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      if (d < 0) begin
         d = -d;
      end
      return d[31:0];
   endfunction

   // one restoring step of the square root, two radicand bits
   function automatic sq_state_type sqrt_step(input sq_state_type s);
      sq_state_type n;
      logic [35:0]  r;
      logic [35:0]  t;
      r = {s.rem[33:0], s.rad[65:64]};
      t = {1'b0, s.root, 2'b01};
      n.rad = {s.rad[63:0], 2'b00};
      if (r >= t) begin
         n.rem  = r - t;
         n.root = {s.root[31:0], 1'b1};
      end else begin
         n.rem  = r;
         n.root = {s.root[31:0], 1'b0};
      end
      return n;
   endfunction

endpackage

### rtl/rsbd_sqdist.sv
module rsbd_sqdist (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic signed [31:0]   point_x,
   input  logic signed [31:0]   point_y,
   input  logic signed [31:0]   left_x,
   input  logic signed [31:0]   bottom_y,
   input  logic signed [31:0]   right_x,
   input  logic signed [31:0]   top_y,
   output rsbd_pkg::tag_type    out_tag,
   output logic [64:0]          out_sq
);

   rsbd_pkg::tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   rsbd_pkg::tag_type tag1_in;

   logic [31:0] gxs_ff, gys_ff, gl_ff, gr_ff, gb_ff, gt_ff;
   logic [31:0] gxs_in, gys_in;
   logic [63:0] sxs_ff, sys_ff, sl_ff, sr_ff, sb_ff, st_ff;
   logic [64:0] dbot_ff, drgt_ff, dtop_ff, dlft_ff;
   logic [64:0] m0_ff, m1_ff, min_ff;

   logic signed [31:0] xlo, xhi, ylo, yhi;
   logic in_box, on_edge;

   // stage 1: gaps to each side span and region test
   always_comb begin
      xlo = (left_x < right_x) ? left_x : right_x;
      xhi = (left_x < right_x) ? right_x : left_x;
      ylo = (bottom_y < top_y) ? bottom_y : top_y;
      yhi = (bottom_y < top_y) ? top_y : bottom_y;
      if (point_x < xlo) begin
         gxs_in = rsbd_pkg::abs_diff(xlo, point_x);
      end else if (point_x > xhi) begin
         gxs_in = rsbd_pkg::abs_diff(point_x, xhi);
      end else begin
         gxs_in = '0;
      end
      if (point_y < ylo) begin
         gys_in = rsbd_pkg::abs_diff(ylo, point_y);
      end else if (point_y > yhi) begin
         gys_in = rsbd_pkg::abs_diff(point_y, yhi);
      end else begin
         gys_in = '0;
      end
      in_box = point_x >= left_x && point_x <= right_x &&
               point_y >= bottom_y && point_y <= top_y;
      on_edge = point_x == left_x || point_x == right_x ||
                point_y == bottom_y || point_y == top_y;
      tag1_in.valid = in_valid;
      if (!in_box) begin
         tag1_in.region = rsbd_pkg::RegionOutside;
      end else if (on_edge) begin
         tag1_in.region = rsbd_pkg::RegionBoundary;
      end else begin
         tag1_in.region = rsbd_pkg::RegionInside;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
      end else if (advance) begin
         tag1_ff.valid <= tag1_in.valid;
         tag2_ff.valid <= tag1_ff.valid;
         tag3_ff.valid <= tag2_ff.valid;
         tag4_ff.valid <= tag3_ff.valid;
         tag5_ff.valid <= tag4_ff.valid;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         // stage 1
         tag1_ff.region <= tag1_in.region;
         gxs_ff <= gxs_in;
         gys_ff <= gys_in;
         gl_ff  <= rsbd_pkg::abs_diff(point_x, left_x);
         gr_ff  <= rsbd_pkg::abs_diff(point_x, right_x);
         gb_ff  <= rsbd_pkg::abs_diff(point_y, bottom_y);
         gt_ff  <= rsbd_pkg::abs_diff(point_y, top_y);
         // stage 2: squares
         tag2_ff.region <= tag1_ff.region;
         sxs_ff <= 64'(gxs_ff) * 64'(gxs_ff);
         sys_ff <= 64'(gys_ff) * 64'(gys_ff);
         sl_ff  <= 64'(gl_ff) * 64'(gl_ff);
         sr_ff  <= 64'(gr_ff) * 64'(gr_ff);
         sb_ff  <= 64'(gb_ff) * 64'(gb_ff);
         st_ff  <= 64'(gt_ff) * 64'(gt_ff);
         // stage 3: squared distance to each side
         tag3_ff.region <= tag2_ff.region;
         dbot_ff <= 65'(sxs_ff) + 65'(sb_ff);
         drgt_ff <= 65'(sr_ff) + 65'(sys_ff);
         dtop_ff <= 65'(sxs_ff) + 65'(st_ff);
         dlft_ff <= 65'(sl_ff) + 65'(sys_ff);
         // stage 4: pairwise minimum
         tag4_ff.region <= tag3_ff.region;
         m0_ff <= (drgt_ff < dbot_ff) ? drgt_ff : dbot_ff;
         m1_ff <= (dlft_ff < dtop_ff) ? dlft_ff : dtop_ff;
         // stage 5: final minimum
         tag5_ff.region <= tag4_ff.region;
         min_ff <= (m1_ff < m0_ff) ? m1_ff : m0_ff;
      end
   end

   assign out_tag = tag5_ff;
   assign out_sq  = min_ff;

endmodule

### rtl/rsbd_isqrt.sv
module rsbd_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  rsbd_pkg::tag_type  in_tag,
   input  logic [64:0]        in_sq,
   output rsbd_pkg::tag_type  out_tag,
   output logic [32:0]        out_root
);

   rsbd_pkg::tag_type      tag_ff [rsbd_pkg::SqrtStages];
   rsbd_pkg::sq_state_type st_ff  [rsbd_pkg::SqrtStages];
   rsbd_pkg::sq_state_type st_in  [rsbd_pkg::SqrtStages];
   rsbd_pkg::tag_type      tag_in [rsbd_pkg::SqrtStages];

   // stage inputs
   always_comb begin
      rsbd_pkg::sq_state_type s;
      for (int k = 0; k < rsbd_pkg::SqrtStages; k++) begin
         if (k == 0) begin
            s.rad  = {1'b0, in_sq};
            s.rem  = '0;
            s.root = '0;
            tag_in[k] = in_tag;
         end else begin
            s = st_ff[k-1];
            tag_in[k] = tag_ff[k-1];
         end
         // StepsPerStage steps per stage
         for (int j = 0; j < rsbd_pkg::StepsPerStage; j++) begin
            s = rsbd_pkg::sqrt_step(s);
         end
         st_in[k] = s;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < rsbd_pkg::SqrtStages; k++) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (advance) begin
            tag_ff[k].valid <= tag_in[k].valid;
         end
         if (advance) begin
            tag_ff[k].region <= tag_in[k].region;
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_tag  = tag_ff[rsbd_pkg::SqrtStages-1];
   assign out_root = st_ff[rsbd_pkg::SqrtStages-1].root;

endmodule

### rtl/rect_signed_boundary_distance_top.sv
// pipeline: 5 distance stages, 11 square root stages of three steps each,
// 1 output register
// throughput: one item per cycle; all stages hold while a stalled output has a result
// reset: synchronous, active high; clears all valid bits and the four corner
// registers to zero
module rect_signed_boundary_distance_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [33:0] rsp_signed_distance,
   output logic [1:0]         rsp_region,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic signed [31:0] left_x_ff, bottom_y_ff, right_x_ff, top_y_ff;
   logic               advance;
   rsbd_pkg::tag_type  dist_tag, root_tag;
   logic [64:0]        dist_sq;
   logic [32:0]        root;
   logic               rsp_valid_ff;
   logic signed [33:0] distance_ff, distance_in;
   logic [1:0]         region_ff;

   // configuration registers
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_x_ff   <= '0;
         bottom_y_ff <= '0;
         right_x_ff  <= '0;
         top_y_ff    <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            rsbd_pkg::RegLeftX:   left_x_ff   <= csr_pwdata;
            rsbd_pkg::RegBottomY: bottom_y_ff <= csr_pwdata;
            rsbd_pkg::RegRightX:  right_x_ff  <= csr_pwdata;
            rsbd_pkg::RegTopY:    top_y_ff    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         rsbd_pkg::RegLeftX:   csr_prdata = left_x_ff;
         rsbd_pkg::RegBottomY: csr_prdata = bottom_y_ff;
         rsbd_pkg::RegRightX:  csr_prdata = right_x_ff;
         rsbd_pkg::RegTopY:    csr_prdata = top_y_ff;
         default:              csr_prdata = '0;
      endcase
   end

   // pipeline moves unless a result is held at the output
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   rsbd_sqdist u_sqdist (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .left_x   (left_x_ff),
      .bottom_y (bottom_y_ff),
      .right_x  (right_x_ff),
      .top_y    (top_y_ff),
      .out_tag  (dist_tag),
      .out_sq   (dist_sq)
   );

   rsbd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_tag   (dist_tag),
      .in_sq    (dist_sq),
      .out_tag  (root_tag),
      .out_root (root)
   );

   // sign from the region
   always_comb begin
      case (root_tag.region)
         rsbd_pkg::RegionInside:   distance_in = $signed({1'b0, root});
         rsbd_pkg::RegionBoundary: distance_in = '0;
         default:                  distance_in = -$signed({1'b0, root});
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= root_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         distance_ff <= distance_in;
         region_ff   <= root_tag.region;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_signed_distance = distance_ff;
   assign rsp_region          = region_ff;

`ifndef ASSERT_OFF
   // region code is never the unused value
   a_region_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region == rsbd_pkg::RegionOutside ||
                     rsp_region == rsbd_pkg::RegionBoundary ||
                     rsp_region == rsbd_pkg::RegionInside))
      else $error("bad region code");

   // inside gives a non-negative distance
   a_inside_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region == rsbd_pkg::RegionInside |-> !rsp_signed_distance[33])
      else $error("negative distance inside");

   // a held result keeps the pipeline frozen
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_signed_distance))
      else $error("held item lost");
`endif

endmodule

### tb/rect_signed_boundary_distance_top_tb.sv
`timescale 1ns / 100ps

// expected-result store for the distance pipeline
class distance_scoreboard;
   logic signed [31:0] left_x, bottom_y, right_x, top_y;
   logic signed [33:0] exp_dist[$];
   logic [1:0]         exp_region[$];
   int                 errors;
   int                 checked;
   int                 region_seen[3];

   function new();
      left_x = 0; bottom_y = 0; right_x = 0; top_y = 0;
      errors = 0; checked = 0;
   endfunction

   // gap from p to the closed interval between a and b
   function automatic logic [32:0] span_gap(logic signed [31:0] p, logic signed [31:0] a,
                                            logic signed [31:0] b);
      logic signed [32:0] lo;
      logic signed [32:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (p < lo) return 33'(lo - p);
      if (p > hi) return 33'(p - hi);
      return 33'd0;
   endfunction

   function automatic logic [65:0] seg_sq(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] ax, logic signed [31:0] ay,
                                          logic signed [31:0] bx, logic signed [31:0] by);
      logic [65:0] dx;
      logic [65:0] dy;
      dx = span_gap(px, ax, bx);
      dy = span_gap(py, ay, by);
      return dx * dx + dy * dy;
   endfunction

   function automatic logic [32:0] floor_sqrt(logic [65:0] v);
      logic [67:0] rem;
      logic [67:0] trial;
      logic [32:0] root;
      rem = 0; root = 0;
      for (int i = 32; i >= 0; i--) begin
         rem = (rem << 2) | 68'((v >> (2 * i)) & 66'd3);
         trial = {33'd0, root, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            root = {root[31:0], 1'b1};
         end else begin
            root = {root[31:0], 1'b0};
         end
      end
      return root;
   endfunction

   // work out the expected result of one accepted point
   function void note_point(logic signed [31:0] px, logic signed [31:0] py);
      logic [65:0] best;
      logic [65:0] sq;
      logic [32:0] root_val;
      logic        in_box, on_edge;
      best = seg_sq(px, py, left_x, bottom_y, right_x, bottom_y);
      sq = seg_sq(px, py, right_x, bottom_y, right_x, top_y);
      if (sq < best) best = sq;
      sq = seg_sq(px, py, right_x, top_y, left_x, top_y);
      if (sq < best) best = sq;
      sq = seg_sq(px, py, left_x, top_y, left_x, bottom_y);
      if (sq < best) best = sq;
      root_val = floor_sqrt(best);
      in_box = px >= left_x && px <= right_x && py >= bottom_y && py <= top_y;
      on_edge = px == left_x || px == right_x || py == bottom_y || py == top_y;
      if (!in_box) begin
         exp_dist.push_back(-$signed({1'b0, root_val}));
         exp_region.push_back(rsbd_pkg::RegionOutside);
      end else if (on_edge) begin
         exp_dist.push_back(34'sd0);
         exp_region.push_back(rsbd_pkg::RegionBoundary);
      end else begin
         exp_dist.push_back($signed({1'b0, root_val}));
         exp_region.push_back(rsbd_pkg::RegionInside);
      end
   endfunction

   function void check_result(logic signed [33:0] got_dist, logic [1:0] region);
      logic signed [33:0] ed;
      logic [1:0]         er;
      if (exp_dist.size() == 0) begin
         $display("%0t: unexpected result dist=%0d region=%0d", $time, got_dist, region);
         errors++;
         return;
      end
      ed = exp_dist.pop_front();
      er = exp_region.pop_front();
      checked++;
      if (er < 3) region_seen[er]++;
      if (got_dist !== ed) begin
         $display("%0t: distance mismatch expected %0d actual %0d", $time, ed, got_dist);
         errors++;
      end
      if (region !== er) begin
         $display("%0t: region mismatch expected %0d actual %0d", $time, er, region);
         errors++;
      end
   endfunction
endclass

module rect_signed_boundary_distance_top_tb;

   localparam int RandomItems = 1950;
   localparam int Latency     = 17;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [33:0] rsp_signed_distance;
   logic [1:0]         rsp_region;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [3:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   distance_scoreboard board;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_off;
   bit  stim_done;

   rect_signed_boundary_distance_top DUT (.*);

   // clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // watchdog
   initial begin
      #20ms;
      $display("rect_signed_boundary_distance_top_tb NOT OK");
      $finish;
   end

   // output side: random stall, long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_signed_distance, rsp_region);
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // register write through the configuration port
   task automatic write_reg(logic [1:0] idx, logic signed [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         rsbd_pkg::RegLeftX:   board.left_x = value;
         rsbd_pkg::RegBottomY: board.bottom_y = value;
         rsbd_pkg::RegRightX:  board.right_x = value;
         rsbd_pkg::RegTopY:    board.top_y = value;
         default: ;
      endcase
   endtask

   task automatic set_rect(logic signed [31:0] lx, logic signed [31:0] by,
                           logic signed [31:0] rx, logic signed [31:0] ty);
      write_reg(rsbd_pkg::RegLeftX, lx);
      write_reg(rsbd_pkg::RegBottomY, by);
      write_reg(rsbd_pkg::RegRightX, rx);
      write_reg(rsbd_pkg::RegTopY, ty);
   endtask

   // offer one point, hold it until accepted
   task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_point(px, py);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.exp_dist.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_word();
      return $urandom();
   endfunction

   // a coordinate near one of the rectangle's sides, or now and then a random word
   function automatic logic signed [31:0] near(logic signed [31:0] a, logic signed [31:0] b);
      case ($urandom_range(4))
         0: return a;
         1: return b;
         2: return a + $signed(32'($urandom_range(6)) - 32'sd3);
         3: return b + $signed(32'($urandom_range(6)) - 32'sd3);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_rect();
      logic signed [31:0] a, b, c, d;
      case ($urandom_range(5))
         0: begin a = rand_word(); b = rand_word(); c = rand_word(); d = rand_word(); end
         1: begin
            a = $signed($urandom_range(2000)) - 1000; b = $signed($urandom_range(2000)) - 1000;
            c = a + $urandom_range(40); d = b + $urandom_range(40);
         end
         2: begin a = rand_word(); b = rand_word(); c = a; d = b; end
         default: begin
            a = rand_word() >>> 1; b = rand_word() >>> 1;
            c = a + $urandom_range(32'h3fffffff); d = b + $urandom_range(32'h3fffffff);
         end
      endcase
      set_rect(a, b, c, d);
   endtask

   // long output hold-off while the input keeps offering
   initial begin
      hold_off = 1'b0;
      @(posedge clock);
      while (stim_done || board == null || board.checked <= 200) @(posedge clock);
      hold_off <= 1'b1;
      repeat (120) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      logic signed [31:0] lx, by, rx, ty;
      int sent;
      board = new();
      stim_done = 1'b0;
      send_idle_pct = 32;
      recv_idle_pct = 32;
      reset = 1'b1;
      req_valid = 1'b0; req_point_x = 0; req_point_y = 0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = 0; csr_pwdata = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // degenerate rectangle from reset, then the full extremes
      send_point(0, 0);
      send_point(32'sh7fffffff, 32'sh80000000);
      send_point(32'sh80000000, 32'sh7fffffff);
      drain();
      set_rect(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
      send_point(0, 0);
      send_point(32'sh80000000, 0);
      send_point(32'sh7fffffff, 32'sh7fffffff);
      send_point(32'sh80000001, 32'sh7ffffffe);
      drain();
      // ordinary box: inside, left and top edges, a corner, points outside
      set_rect(-32'sd100, -32'sd50, 32'sd100, 32'sd50);
      send_point(0, 0);
      send_point(-100, 10);
      send_point(100, -50);
      send_point(5, 50);
      send_point(300, 400);
      send_point(-103, -54);
      send_point(0, 90);
      drain();
      // inverted box: region never inside, distance may hit zero on a segment
      set_rect(32'sd100, 32'sd50, -32'sd100, -32'sd50);
      send_point(0, 50);
      send_point(0, 0);
      send_point(32'sh7fffffff, 32'sh80000000);
      drain();
      // reversed full extremes
      set_rect(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
      send_point(32'sh80000000, 32'sh80000000);
      send_point(32'sh7fffffff, 0);
      drain();

      // random phases; one burst without idling, one full pause
      sent = 0;
      for (int ph = 0; sent < RandomItems; ph++) begin
         random_rect();
         lx = board.left_x; by = board.bottom_y; rx = board.right_x; ty = board.top_y;
         if (ph == 3) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end else begin
            send_idle_pct = 32; recv_idle_pct = 32;
         end
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(9) < 8) send_point(near(lx, rx), near(by, ty));
            else send_point(rand_word(), rand_word());
            sent++;
         end
         drain();
      end
      stim_done = 1'b1;
      drain();
      repeat (Latency * 2) @(posedge clock);

      $display("checked %0d results: %0d outside, %0d boundary, %0d inside", board.checked,
               board.region_seen[0], board.region_seen[1], board.region_seen[2]);
      if (board.errors == 0 && board.exp_dist.size() == 0) begin
         $display("rect_signed_boundary_distance_top_tb OK");
      end else begin
         $display("rect_signed_boundary_distance_top_tb NOT OK");
      end
      $finish;
   end

endmodule
